/* rtl/jlgs_pkg.sv */
// Shared types and constants for the Jacobi grid solver.
package jlgs_pkg;

    localparam int GRID_MAX   = 64;
    localparam int IDX_W      = $clog2(GRID_MAX);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int SIZE_W     = 7;
    localparam logic [30:0] ERR_ONES = 31'h7FFF_FFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_GRID_SIZE = 2'd0;
    localparam logic [1:0] REG_MAX_ITER  = 2'd1;
    localparam logic [1:0] REG_TOLERANCE = 2'd2;
    localparam logic [1:0] REG_PAIRS     = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] cell_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [15:0]        sweeps_done;
        logic [30:0]        last_error;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HOST_RD,
        ST_COPY,
        ST_SWEEP,
        ST_DRAIN,
        ST_ROUND,
        ST_DONE,
        ST_OUT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic             host_wr;
        logic             copy_en;
        logic             sweep_en;
        logic             dir;       // 0: main -> scratch, 1: scratch -> main
        logic             track;
        logic             err_clr;
        logic [ADDR_W-1:0] addr;     // cell being processed
    } dp_cmd_t;

    typedef struct packed {
        logic [30:0] worst;
    } dp_stat_t;

endpackage

/* rtl/jlgs_datapath.sv */
// Grid memories, stencil arithmetic and error tracking.
module jlgs_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  jlgs_pkg::dp_cmd_t      cmd,
    input  jlgs_pkg::in_item_t     item,
    output logic signed [31:0]     rd_data,
    output jlgs_pkg::dp_stat_t     stat
);
    import jlgs_pkg::*;

    // Each grid is banked by neighbor direction: five copies (four taps plus the
    // cell itself) written together so that the four stencil taps are read at once.
    logic signed [31:0] m_n [GRID_MAX*GRID_MAX];
    logic signed [31:0] m_s [GRID_MAX*GRID_MAX];
    logic signed [31:0] m_w [GRID_MAX*GRID_MAX];
    logic signed [31:0] m_e [GRID_MAX*GRID_MAX];
    logic signed [31:0] s_n [GRID_MAX*GRID_MAX];
    logic signed [31:0] s_s [GRID_MAX*GRID_MAX];
    logic signed [31:0] s_w [GRID_MAX*GRID_MAX];
    logic signed [31:0] s_e [GRID_MAX*GRID_MAX];
    logic signed [31:0] m_o [GRID_MAX*GRID_MAX];
    logic signed [31:0] s_o [GRID_MAX*GRID_MAX];

    logic [ADDR_W-1:0] a_n, a_s, a_w, a_e, host_addr;
    logic signed [31:0] tn_reg, ts_reg, tw_reg, te_reg, old_reg;
    logic signed [31:0] copy_reg;
    logic               st1_reg, st2_reg, dir1_reg, dir2_reg, trk1_reg, trk2_reg;
    logic               cp1_reg;
    logic [ADDR_W-1:0]  ad1_reg, ad2_reg;
    logic signed [31:0] new_reg;
    logic signed [33:0] sum;
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [30:0]        e_sat;
    logic [30:0]        worst_reg, worst_next;

    assign host_addr = {item.row, item.col};
    assign a_n = cmd.addr - ADDR_W'(GRID_MAX);
    assign a_s = cmd.addr + ADDR_W'(GRID_MAX);
    assign a_w = cmd.addr - ADDR_W'(1);
    assign a_e = cmd.addr + ADDR_W'(1);

    // Stage 1: read taps, the source grid's old value, copy data and host read data.
    always_ff @(posedge clk)
    begin
        if (cmd.dir)
        begin
            tn_reg <= s_n[a_n];
            ts_reg <= s_s[a_s];
            tw_reg <= s_w[a_w];
            te_reg <= s_e[a_e];
            old_reg <= s_o[cmd.addr];
        end
        else
        begin
            tn_reg <= m_n[a_n];
            ts_reg <= m_s[a_s];
            tw_reg <= m_w[a_w];
            te_reg <= m_e[a_e];
            old_reg <= m_o[cmd.addr];
        end
        copy_reg <= m_o[cmd.addr];
        rd_data  <= m_o[host_addr];
        ad1_reg  <= cmd.addr;
        dir1_reg <= cmd.dir;
        trk1_reg <= cmd.track;
    end

    assign sum = 34'(tn_reg) + 34'(ts_reg) + 34'(tw_reg) + 34'(te_reg);

    // Stage 2: quarter sum.
    always_ff @(posedge clk)
    begin
        new_reg  <= 32'(sum >>> 2);
        ad2_reg  <= ad1_reg;
        dir2_reg <= dir1_reg;
        trk2_reg <= trk1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg <= 1'b0;
            st2_reg <= 1'b0;
            cp1_reg <= 1'b0;
        end
        else
        begin
            st1_reg <= cmd.sweep_en;
            st2_reg <= st1_reg;
            cp1_reg <= cmd.copy_en;
        end
    end

    // Error of the tracked sweep: compare against the source grid at the
    // same cell, i.e. the value of the previous sweep.
    logic signed [31:0] old2_reg;
    always_ff @(posedge clk)
    begin
        old2_reg <= old_reg;
    end

    assign diff  = 33'(new_reg) - 33'(old2_reg);
    assign mag   = diff[32] ? 33'(-diff) : 33'(diff);
    assign e_sat = (mag > 33'(ERR_ONES)) ? ERR_ONES : mag[30:0];

    always_comb
    begin
        worst_next = worst_reg;
        if (cmd.err_clr)
            worst_next = '0;
        else if (st2_reg && trk2_reg && e_sat > worst_reg)
            worst_next = e_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            worst_reg <= '0;
        else
            worst_reg <= worst_next;
    end

    assign stat.worst = worst_reg;

    // Writes: host, copy, sweep results.
    always_ff @(posedge clk)
    begin
        if (cmd.host_wr)
        begin
            m_n[host_addr] <= item.cell_value;
            m_s[host_addr] <= item.cell_value;
            m_w[host_addr] <= item.cell_value;
            m_e[host_addr] <= item.cell_value;
            m_o[host_addr] <= item.cell_value;
        end
        else if (st2_reg && dir2_reg)
        begin
            m_n[ad2_reg] <= new_reg;
            m_s[ad2_reg] <= new_reg;
            m_w[ad2_reg] <= new_reg;
            m_e[ad2_reg] <= new_reg;
            m_o[ad2_reg] <= new_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cp1_reg)
        begin
            s_n[ad1_reg] <= copy_reg;
            s_s[ad1_reg] <= copy_reg;
            s_w[ad1_reg] <= copy_reg;
            s_e[ad1_reg] <= copy_reg;
            s_o[ad1_reg] <= copy_reg;
        end
        else if (st2_reg && !dir2_reg)
        begin
            s_n[ad2_reg] <= new_reg;
            s_s[ad2_reg] <= new_reg;
            s_w[ad2_reg] <= new_reg;
            s_e[ad2_reg] <= new_reg;
            s_o[ad2_reg] <= new_reg;
        end
    end

endmodule

/* rtl/jlgs_ctrl.sv */
// Sequencer for host accesses, grid copy and sweep rounds.
module jlgs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  jlgs_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output jlgs_pkg::out_item_t  out_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [30:0]          cfg_data,
    output jlgs_pkg::dp_cmd_t    cmd,
    input  jlgs_pkg::dp_stat_t   stat,
    input  logic signed [31:0]   rd_data
);
    import jlgs_pkg::*;

    state_t state_reg, state_next;
    logic [SIZE_W-1:0] gsize_reg;
    logic [15:0]       maxit_reg;
    logic [30:0]       tol_reg;
    logic [7:0]        ppc_reg;

    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next;
    logic [8:0]        sw_reg, sw_next;     // sweep within round
    logic [1:0]        dr_reg, dr_next;     // pipeline drain count
    logic [15:0]       cnt_reg, cnt_next;
    logic [30:0]       err_reg, err_next;
    logic              chk_reg, chk_next;
    logic [15:0]       scnt_reg, scnt_next;
    logic [30:0]       serr_reg, serr_next;
    out_item_t         oi_reg, oi_next;
    logic              ov_reg, ov_next;

    logic [SIZE_W-1:0] n_eff;
    logic [7:0]        ppc_eff;
    logic [8:0]        sweeps_round;
    logic [IDX_W-1:0]  last_in, last_all;
    logic              small_grid, out_free;
    logic [16:0]       cnt_sum;

    assign n_eff    = (gsize_reg > SIZE_W'(GRID_MAX)) ? SIZE_W'(GRID_MAX) : gsize_reg;
    assign ppc_eff  = (ppc_reg == 8'd0) ? 8'd1 : ppc_reg;
    assign sweeps_round = {ppc_eff, 1'b0};
    assign small_grid = n_eff < SIZE_W'(3);
    assign last_in  = IDX_W'(n_eff - SIZE_W'(2));
    assign last_all = IDX_W'(n_eff - SIZE_W'(1));
    assign cnt_sum  = 17'(cnt_reg) + 17'(sweeps_round);
    assign out_free = !ov_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg <= SIZE_W'(64);
            maxit_reg <= 16'd1000;
            tol_reg   <= 31'd66;
            ppc_reg   <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_SIZE: gsize_reg <= cfg_data[SIZE_W-1:0];
                REG_MAX_ITER:  maxit_reg <= cfg_data[15:0];
                REG_TOLERANCE: tol_reg   <= cfg_data;
                REG_PAIRS:     ppc_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg <= '0; j_reg <= '0; sw_reg <= '0; dr_reg <= '0;
            cnt_reg <= '0; err_reg <= ERR_ONES; chk_reg <= 1'b0;
            scnt_reg <= '0; serr_reg <= ERR_ONES;
            ov_reg <= 1'b0; oi_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next; j_reg <= j_next; sw_reg <= sw_next; dr_reg <= dr_next;
            cnt_reg <= cnt_next; err_reg <= err_next; chk_reg <= chk_next;
            scnt_reg <= scnt_next; serr_reg <= serr_next;
            ov_reg <= ov_next; oi_reg <= oi_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_item  = oi_reg;

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg; j_next = j_reg; sw_next = sw_reg; dr_next = dr_reg;
        cnt_next = cnt_reg; err_next = err_reg; chk_next = chk_reg;
        scnt_next = scnt_reg; serr_next = serr_reg;
        ov_next = ov_reg && out_stall;
        oi_next = oi_reg;
        in_stall = 1'b1;
        cmd = '0;
        cmd.addr = {i_reg, j_reg};
        cmd.dir = sw_reg[0];
        cmd.track = (sw_reg == sweeps_round - 9'd1);

        case (state_reg)
            ST_IDLE:
            begin
                // a read is held off until its cell data is registered
                in_stall = !out_free || (in_item.kind == KIND_READ);
                if (in_valid && !in_stall)
                begin
                    case (in_item.kind)
                        KIND_WRITE:
                        begin
                            cmd.host_wr = 1'b1;
                            ov_next = 1'b1;
                            oi_next = '{32'sd0, scnt_reg, serr_reg};
                        end
                        KIND_RUN:
                        begin
                            i_next = '0; j_next = '0;
                            cnt_next = '0; err_next = ERR_ONES; chk_next = 1'b0;
                            state_next = ST_COPY;
                        end
                        KIND_READ: ;
                        default:
                        begin
                            ov_next = 1'b1;
                            oi_next = '{32'sd0, scnt_reg, serr_reg};
                        end
                    endcase
                end
                else if (in_valid && in_item.kind == KIND_READ)
                    state_next = ST_HOST_RD;
            end
            ST_HOST_RD:
            begin
                // host address still held: stall keeps payload stable
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free && in_valid)
                begin
                    ov_next = 1'b1;
                    oi_next = '{rd_data, scnt_reg, serr_reg};
                    in_stall = 1'b0;
                    state_next = ST_IDLE;
                    // the read item is taken only now
                end
            end
            ST_COPY:
            begin
                cmd.copy_en = 1'b1;
                if (j_reg == last_all)
                begin
                    j_next = '0;
                    if (i_reg == last_all)
                    begin
                        i_next = '0;
                        state_next = ST_ROUND;
                    end
                    else
                        i_next = i_reg + IDX_W'(1);
                end
                else
                    j_next = j_reg + IDX_W'(1);
            end
            ST_ROUND:
            begin
                if (cnt_reg < maxit_reg && (!chk_reg || err_reg > tol_reg))
                begin
                    sw_next = '0;
                    i_next = IDX_W'(1); j_next = IDX_W'(1);
                    cmd.err_clr = 1'b1;
                    state_next = small_grid ? ST_DRAIN : ST_SWEEP;
                    dr_next = '0;
                end
                else
                    state_next = ST_DONE;
            end
            ST_SWEEP:
            begin
                cmd.sweep_en = 1'b1;
                if (j_reg == last_in)
                begin
                    j_next = IDX_W'(1);
                    if (i_reg == last_in)
                    begin
                        i_next = IDX_W'(1);
                        dr_next = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                        i_next = i_reg + IDX_W'(1);
                end
                else
                    j_next = j_reg + IDX_W'(1);
            end
            ST_DRAIN:
            begin
                // let the two pipeline stages write back before the next sweep or the stop check
                dr_next = dr_reg + 2'd1;
                if (dr_reg == 2'd2)
                begin
                    if (small_grid || sw_reg == sweeps_round - 9'd1)
                    begin
                        err_next = small_grid ? 31'd0 : stat.worst;
                        chk_next = 1'b1;
                        cnt_next = cnt_sum[16] ? COUNT_MAX : cnt_sum[15:0];
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        sw_next = sw_reg + 9'd1;
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    scnt_next = cnt_reg;
                    serr_next = err_reg;
                    ov_next = 1'b1;
                    oi_next = '{32'sd0, cnt_reg, err_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/jacobi_laplace_grid_solver.sv */
// Top level of the Jacobi grid solver: controller plus datapath.
// Jacobi solver for the 2-D Laplace equation (five-point stencil) on a square
// grid of up to 64x64 Q16.16 cells with a fixed boundary. Each input transfer
// writes a cell (kind 0), runs the solver (kind 1) or reads a cell (kind 2);
// every transfer yields exactly one result transfer carrying the read value
// (zero unless a read) with the sweep count and error of the last run. A cell
// write is taken once the output is free; a cell read is stalled until its
// cell data is registered (ST_HOST_RD) and is taken in ST_OUT. A run
// transfer is taken like a write and the input stays stalled until its
// result is out: it copies the n*n grid to the scratch buffer, then runs
// rounds of 2*pairs_per_check sweeps; the datapath processes one interior
// cell per cycle through a two-stage read/add pipeline that drains after
// each sweep, with a stop check between rounds. The four stencil taps come
// from banked copies of each grid, so every cell update needs only one read
// port per bank. Configuration writes belong between transfers, while the
// block is idle.
module jacobi_laplace_grid_solver (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  jlgs_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output jlgs_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [30:0]          cfg_data
);
    import jlgs_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic signed [31:0] rd_data;

    jlgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rd_data   (rd_data)
    );

    jlgs_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .item    (in_data),
        .rd_data (rd_data),
        .stat    (stat)
    );

endmodule
